// ===== hdl/tmp_pkg.sv =====
// Shared types, widths and codes for the trapezoidal motion profile.
// No dependencies; every other file imports this package.
package tmp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 24;
	localparam int TIME_W    = 28;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_W     = VAL_W + 2 * FRAC_BITS;
	localparam int REM_W     = VAL_W + 1;
	localparam int ROOT_W    = NUM_W / 2;
	localparam int SREM_W    = ROOT_W + 2;
	localparam int TS_W      = VAL_W + FRAC_BITS + 1;
	localparam int TT_W      = TS_W + 1;
	localparam int OP_W      = TIME_W + 1;
	localparam int PROD_W    = VAL_W + OP_W;
	localparam int CNT_W     = $clog2(NUM_W);

	localparam logic [CFG_IDX_W-1:0] REG_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACC = 2'd2;

	typedef enum logic [1:0] {
		PH_ACCEL  = 2'd0,
		PH_CRUISE = 2'd1,
		PH_DECEL  = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		S_MUL_LA,
		S_MUL_VV,
		S_DIV_TS,
		S_DIV_TC,
		S_DIV_RAD,
		S_SQRT,
		S_FINAL,
		S_READY
	} st_t;

	typedef struct packed {
		logic              busy;
		logic [VAL_W-1:0]  len;
		logic [VAL_W-1:0]  vel;
		logic [VAL_W-1:0]  acc;
		logic [TS_W-1:0]   ts;
		logic [TS_W-1:0]   tc;
		logic [TT_W-1:0]   tt;
	} prof_t;

	typedef struct packed {
		phase_t            phase;
		logic [OP_W-1:0]   op;
	} item_t;

endpackage

// ===== hdl/tmp_setup.sv =====
// Configuration registers and the sequencer that derives ramp, cruise and total times.
// Uses tmp_pkg; one shared bit-serial divider and a bit-pair square root unit.
module tmp_setup import tmp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	output prof_t                prof
);

	logic [VAL_W-1:0] len_q, vel_q, acc_q, v_eff, a_eff, den;
	st_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic div_last, sq_last;
	logic [2*VAL_W-1:0] la_q, vv_q;
	logic [NUM_W-1:0] num_q, quo_q, quo_n;
	logic [REM_W-1:0] rem_q, rem_n;
	logic [REM_W:0] rem_sh;
	logic ge;
	logic [SREM_W-1:0] srem_q, srem_n;
	logic [SREM_W+1:0] s_sh, trial;
	logic sge;
	logic [ROOT_W-1:0] root_q, root_n;
	logic [TS_W-1:0] tsd_q, tcd_q, ts_q, tc_q, ts_c, tc_c;
	logic [TT_W-1:0] tt_q;
	logic cruise;

	assign v_eff = (vel_q == '0) ? VAL_W'(1) : vel_q;
	assign a_eff = (acc_q == '0) ? VAL_W'(1) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			vel_q <= VAL_W'(1) << FRAC_BITS;
			acc_q <= VAL_W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEN: len_q <= cfg_data;
				REG_VEL: vel_q <= cfg_data;
				REG_ACC: acc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign div_last = cnt_q == CNT_W'(NUM_W - 1);
	assign sq_last  = cnt_q == CNT_W'(ROOT_W - 1);

	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = S_MUL_LA;
		end else begin
			case (state_q)
				S_MUL_LA:  state_d = S_MUL_VV;
				S_MUL_VV:  state_d = S_DIV_TS;
				S_DIV_TS:  if (div_last) state_d = S_DIV_TC;
				S_DIV_TC:  if (div_last) state_d = S_DIV_RAD;
				S_DIV_RAD: if (div_last) state_d = S_SQRT;
				S_SQRT:    if (sq_last) state_d = S_FINAL;
				S_FINAL:   state_d = S_READY;
				default:   state_d = S_READY;
			endcase
		end
	end

	always_comb begin
		case (state_q)
			S_DIV_TC: den = v_eff;
			default:  den = a_eff;
		endcase
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge     = rem_sh >= (REM_W+1)'(den);
		rem_n  = ge ? REM_W'(rem_sh - (REM_W+1)'(den)) : REM_W'(rem_sh);
		quo_n  = {quo_q[NUM_W-2:0], ge};
		s_sh   = {srem_q, num_q[NUM_W-1:NUM_W-2]};
		trial  = (SREM_W+2)'({root_q, 2'b01});
		sge    = s_sh >= trial;
		srem_n = sge ? SREM_W'(s_sh - trial) : SREM_W'(s_sh);
		root_n = {root_q[ROOT_W-2:0], sge};
		cruise = la_q > vv_q;
		ts_c   = cruise ? tsd_q : TS_W'(root_q);
		tc_c   = cruise ? tcd_q : TS_W'(root_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_MUL_LA;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q || cfg_we) ? '0 : cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_MUL_LA: begin
				la_q  <= len_q * a_eff;
				num_q <= NUM_W'({v_eff, {FRAC_BITS{1'b0}}});
				rem_q <= '0;
			end
			S_MUL_VV: vv_q <= v_eff * v_eff;
			S_DIV_TS, S_DIV_TC, S_DIV_RAD: begin
				quo_q <= quo_n;
				if (div_last) begin
					rem_q <= '0;
					case (state_q)
						S_DIV_TS: begin
							tsd_q <= TS_W'(quo_n);
							num_q <= NUM_W'({len_q, {FRAC_BITS{1'b0}}});
						end
						S_DIV_TC: begin
							tcd_q <= TS_W'(quo_n);
							num_q <= {len_q, {(2*FRAC_BITS){1'b0}}};
						end
						default: begin
							num_q  <= quo_n;
							srem_q <= '0;
							root_q <= '0;
						end
					endcase
				end else begin
					rem_q <= rem_n;
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end
			end
			S_SQRT: begin
				srem_q <= srem_n;
				root_q <= root_n;
				num_q  <= {num_q[NUM_W-3:0], 2'b00};
			end
			S_FINAL: begin
				ts_q <= ts_c;
				tc_q <= tc_c;
				tt_q <= TT_W'(ts_c) + TT_W'(tc_c);
			end
			default: ;
		endcase
	end

	assign prof.busy = state_q != S_READY;
	assign prof.len  = len_q;
	assign prof.vel  = v_eff;
	assign prof.acc  = a_eff;
	assign prof.ts   = ts_q;
	assign prof.tc   = tc_q;
	assign prof.tt   = tt_q;

endmodule

// ===== hdl/tmp_front.sv =====
// Front end: accepts time items, classifies the phase and queues them (two entries).
// Uses tmp_pkg; profile times come from tmp_setup.
module tmp_front import tmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  prof_t             prof,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TIME_W-1:0] elapsed_time,
	input  logic              pop,
	output logic              head_valid,
	output item_t             head
);

	item_t mem_q [2];
	item_t cls;
	logic wr_q, rd_q, push, pop_ok;
	logic [1:0] cnt_q;

	always_comb begin
		cls.op = '0;
		if (TS_W'(elapsed_time) < prof.ts) begin
			cls.phase = PH_ACCEL;
			cls.op    = OP_W'(elapsed_time);
		end else if (TS_W'(elapsed_time) < prof.tc) begin
			cls.phase = PH_CRUISE;
			cls.op    = OP_W'((TS_W'(elapsed_time) << 1) - prof.ts);
		end else if (TT_W'(elapsed_time) < prof.tt) begin
			cls.phase = PH_DECEL;
			cls.op    = OP_W'(prof.tt - TT_W'(elapsed_time));
		end else begin
			cls.phase = PH_DONE;
		end
	end

	assign in_ready   = !prof.busy && cnt_q != 2'd2;
	assign push       = in_valid && in_ready;
	assign head_valid = cnt_q != 2'd0;
	assign pop_ok     = pop && head_valid;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop_ok) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cls;
	end

endmodule

// ===== hdl/tmp_back.sv =====
// Back end: five-stage pipeline computing velocity and position from a queued item.
// Uses tmp_pkg; two registered multiplies, output register is the last stage.
module tmp_back import tmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  prof_t             prof,
	input  logic              head_valid,
	input  item_t             head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VAL_W-1:0]  position,
	output logic [VAL_W-1:0]  velocity,
	output logic [1:0]        phase
);

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	phase_t ph_s1, ph_s2, ph_s3, ph_s4, ph_s5;
	logic [OP_W-1:0] op_s1, op_s2, op_s3;
	logic [PROD_W-1:0] p1_s2, p2_s4, p1_sh, p2_sh;
	logic [VAL_W-1:0] vel_s3, vel_s4, vel_s5, pos_s5, vel_c, pos_c;
	logic [PROD_W-1:0] cpos_s3;

	assign adv = !vld_s5 || out_ready;
	assign pop = adv && head_valid;

	assign p1_sh = p1_s2 >> FRAC_BITS;
	assign p2_sh = p2_s4 >> (FRAC_BITS + 1);

	always_comb begin
		case (ph_s2)
			PH_CRUISE: vel_c = prof.vel;
			PH_DONE:   vel_c = '0;
			default:   vel_c = (p1_sh > PROD_W'({VAL_W{1'b1}})) ? '1 : VAL_W'(p1_sh);
		endcase
		case (ph_s4)
			PH_CRUISE: pos_c = (p2_s4 > PROD_W'(prof.len)) ? prof.len : VAL_W'(p2_s4);
			PH_ACCEL:  pos_c = (p2_sh > PROD_W'(prof.len)) ? prof.len : VAL_W'(p2_sh);
			PH_DECEL:  pos_c = (p2_sh >= PROD_W'(prof.len)) ? '0
			                   : prof.len - VAL_W'(p2_sh);
			default:   pos_c = prof.len;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5} <= '0;
		end else if (adv) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5} <= {head_valid, vld_s1, vld_s2, vld_s3, vld_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s1   <= head.phase;
			op_s1   <= head.op;
			ph_s2   <= ph_s1;
			op_s2   <= op_s1;
			p1_s2   <= ((ph_s1 == PH_CRUISE) ? prof.vel : prof.acc) * op_s1;
			ph_s3   <= ph_s2;
			op_s3   <= op_s2;
			vel_s3  <= vel_c;
			cpos_s3 <= p1_s2 >> (FRAC_BITS + 1);
			ph_s4   <= ph_s3;
			vel_s4  <= vel_s3;
			p2_s4   <= (ph_s3 == PH_CRUISE) ? cpos_s3 : vel_s3 * op_s3;
			ph_s5   <= ph_s4;
			vel_s5  <= vel_s4;
			pos_s5  <= pos_c;
		end
	end

	assign out_valid = vld_s5;
	assign position  = pos_s5;
	assign velocity  = vel_s5;
	assign phase     = ph_s5;

endmodule

// ===== hdl/trapezoidal_motion_profile.sv =====
// Top level of the trapezoidal motion profile.
// Uses tmp_pkg, tmp_setup, tmp_front and tmp_back.
//
// Input channel: in_valid/in_ready with elapsed_time (Q12.16 seconds).
// Output channel: out_valid/out_ready with position, velocity (Q8.16) and
// phase (0 accel, 1 cruise, 2 decel, 3 finished), one result per item, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 length,
// 1 peak velocity, 2 peak acceleration); other indexes are ignored.
// After reset and after every configuration write the setup sequencer
// recomputes the ramp, cruise and total times: two multiplies, three
// bit-serial divisions and a 28-step square root, during which in_ready
// is low.
// Throughput: one item per cycle while out_ready is high and the setup is idle,
// set by the pipelined back end with a multiply in each of two stages.
// An accepted item is written to the queue, then passes back-end stages s1 to s5 to out_valid.
// When the receiver stalls the pipeline holds; the two-entry queue absorbs
// items in flight and in_ready falls once it is full.
module trapezoidal_motion_profile import tmp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_W-1:0]    elapsed_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [VAL_W-1:0]     position,
	output logic [VAL_W-1:0]     velocity,
	output logic [1:0]           phase
);

	prof_t prof;
	item_t head;
	logic head_valid, pop;

	tmp_setup u_setup (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .prof
	);

	tmp_front u_front (
		.clk, .arst_n, .prof, .in_valid, .in_ready, .elapsed_time,
		.pop, .head_valid, .head
	);

	tmp_back u_back (
		.clk, .arst_n, .prof, .head_valid, .head, .pop,
		.out_valid, .out_ready, .position, .velocity, .phase
	);

endmodule

// ===== hdl/tmp_checker.sv =====
// Port-level checks for the trapezoidal motion profile, bound to the top level.
// Uses tmp_pkg for widths and phase codes.
module tmp_checker import tmp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [VAL_W-1:0]     position,
	input logic [VAL_W-1:0]     velocity,
	input logic [1:0]           phase
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(velocity)
		&& $stable(phase))
		else $error("result changed while stalled");

	a_done_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_DONE |-> velocity == '0)
		else $error("finished item with non-zero velocity");

	a_cruise_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_CRUISE |-> velocity != '0)
		else $error("cruising item with zero velocity");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("item taken while profile recomputes");

endmodule

bind trapezoidal_motion_profile tmp_checker u_chk (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for trapezoidal_motion_profile.
// Needs only hdl/tmp_pkg.sv and the RTL; predicts each time sample in a scoreboard class.
`timescale 1ns / 1ps

module testbench;
	import tmp_pkg::*;

	typedef bit [63:0] u64;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam u64 VMAX = 64'hFFFFFF;
	localparam u64 TMAX = 64'hFFFFFFF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [VAL_W-1:0] pos;
		logic [VAL_W-1:0] vel;
		phase_t           ph;
	} motion_t;

	class profile_scoreboard;
		u64 len, vmax, amax;
		motion_t pending[$];
		int mismatches;
		int checked;

		function new();
			len = 0;
			vmax = 65536;
			amax = 65536;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
			case (idx)
				REG_LEN: len = u64'(d);
				REG_VEL: vmax = u64'(d);
				REG_ACC: amax = u64'(d);
				default: ;
			endcase
		endfunction

		function u64 int_sqrt(u64 x);
			u64 r, b;
			r = 0;
			b = u64'(1) << 62;
			while (b > x)
				b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function void ramp_times(output u64 ts, output u64 tc, output u64 tt);
			u64 v, a, q, r;
			v = vmax ? vmax : 1;
			a = amax ? amax : 1;
			if (len * a > v * v) begin
				ts = (v << FRAC_BITS) / a;
				tc = (len << FRAC_BITS) / v;
			end else begin
				q = (len << FRAC_BITS) / a;
				r = (len << FRAC_BITS) % a;
				if (q >= (u64'(1) << (58 - FRAC_BITS)))
					ts = u64'(1) << 29;
				else
					ts = int_sqrt((q << FRAC_BITS) + ((r << FRAC_BITS) / a));
				tc = ts;
			end
			tt = ts + tc;
		endfunction

		function void note_sample(logic [TIME_W-1:0] t_in);
			u64 t, v, a, ts, tc, tt, d, sub, p, vl;
			motion_t m;
			t = u64'(t_in);
			v = vmax ? vmax : 1;
			a = amax ? amax : 1;
			ramp_times(ts, tc, tt);
			if (t < ts) begin
				m.ph = PH_ACCEL;
				vl = (a * t) >> FRAC_BITS;
				if (vl > VMAX) vl = VMAX;
				p = (vl * t) >> (FRAC_BITS + 1);
			end else if (t < tc) begin
				m.ph = PH_CRUISE;
				vl = v;
				p = (v * (2 * t - ts)) >> (FRAC_BITS + 1);
			end else if (t < tt) begin
				m.ph = PH_DECEL;
				d = tt - t;
				vl = (a * d) >> FRAC_BITS;
				if (vl > VMAX) vl = VMAX;
				sub = (vl * d) >> (FRAC_BITS + 1);
				p = sub >= len ? 0 : len - sub;
			end else begin
				m.ph = PH_DONE;
				vl = 0;
				p = len;
			end
			if (p > len) p = len;
			m.pos = p[VAL_W-1:0];
			m.vel = vl[VAL_W-1:0];
			pending.push_back(m);
		endfunction

		function void check_motion(logic [VAL_W-1:0] pos, logic [VAL_W-1:0] vel,
				logic [1:0] ph);
			motion_t m;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result pos=%h vel=%h phase=%0d", pos, vel, ph);
				return;
			end
			m = pending.pop_front();
			if (pos !== m.pos || vel !== m.vel || ph !== m.ph) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch #%0d: exp pos=%h vel=%h phase=%0d, got pos=%h vel=%h phase=%0d",
						checked, m.pos, m.vel, m.ph, pos, vel, ph);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [TIME_W-1:0]    elapsed_time;
	logic                 out_valid;
	logic                 out_ready;
	logic [VAL_W-1:0]     position;
	logic [VAL_W-1:0]     velocity;
	logic [1:0]           phase;

	profile_scoreboard sb;
	bit quiet_in, quiet_out;
	int idle_cycles;
	int samples_sent;
	int settings_used;

	trapezoidal_motion_profile i_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .elapsed_time,
		.out_valid, .out_ready, .position, .velocity, .phase
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function logic [VAL_W-1:0] rand_val();
		return VAL_W'($urandom_range(0, 32'hFFFFFF) >> $urandom_range(0, 23));
	endfunction

	// Sample time skewed towards the phase boundaries of the current setting
	function logic [TIME_W-1:0] pick_time();
		u64 ts, tc, tt, t, base;
		sb.ramp_times(ts, tc, tt);
		case ($urandom_range(0, 5))
			0: base = ts;
			1: base = tc;
			2: base = tt;
			3: base = (tt > TMAX) ? u64'($urandom_range(0, 32'hFFFFFFF))
			                      : u64'($urandom_range(0, tt[31:0]));
			default: base = u64'($urandom_range(0, 32'hFFFFFFF) >> $urandom_range(0, 27));
		endcase
		t = base + u64'($urandom_range(0, 8)) - 4;
		if (base < 4 && t > base + 4) t = u64'($urandom_range(0, 4));
		if (t > TMAX) t = $urandom_range(0, 1) ? TMAX : u64'($urandom_range(0, 32'hFFFFFFF));
		return t[TIME_W-1:0];
	endfunction

	task automatic send_sample(logic [TIME_W-1:0] t);
		int gap;
		gap = pick_gap(quiet_in);
		if (gap > 0 && in_valid) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		elapsed_time <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_sample(t);
		samples_sent++;
	endtask

	task automatic drain();
		if (in_valid) in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_profile(logic [VAL_W-1:0] l, logic [VAL_W-1:0] v,
			logic [VAL_W-1:0] a);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LEN;
		cfg_data  <= l;
		@(posedge clk);
		cfg_index <= REG_VEL;
		cfg_data  <= v;
		@(posedge clk);
		cfg_index <= REG_ACC;
		cfg_data  <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_LEN, l);
		sb.set_reg(REG_VEL, v);
		sb.set_reg(REG_ACC, a);
		settings_used++;
	endtask

	// Receiver with random back-pressure
	initial begin
		int stall;
		out_ready = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_motion(position, velocity, phase);
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				stall = pick_gap(quiet_out);
				out_ready <= (stall == 0);
			end
		end
	end

	// Watchdog on cycles without any item moving
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else if (++idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", idle_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LEN;
		cfg_data = '0;
		in_valid = 1'b0;
		elapsed_time = '0;
		quiet_in = 1'b0;
		quiet_out = 1'b0;
		samples_sent = 0;
		settings_used = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length after reset: always finished
		send_sample('0);
		send_sample(TMAX[TIME_W-1:0]);
		send_sample(28'h5555555);
		send_sample(28'hAAAAAAA);
		write_profile(24'h010000, 24'h010000, 24'h010000);
		send_sample(28'h0);
		send_sample(28'h0FFFF);
		send_sample(28'h10000);
		send_sample(28'h1FFFF);
		send_sample(28'h20000);
		write_profile(VMAX[23:0], 24'd1, 24'd1);   // long cruise at minimum speed
		send_sample(28'h0FFFF);
		send_sample(28'h10000);
		send_sample(TMAX[TIME_W-1:0]);
		write_profile(VMAX[23:0], VMAX[23:0], VMAX[23:0]);
		send_sample(28'h1);
		send_sample(28'h10000);
		send_sample(28'h20000);
		write_profile(24'd1, 24'd0, 24'd0);        // zero registers act as one
		send_sample(28'h0);
		send_sample(28'h100);
		send_sample(TMAX[TIME_W-1:0]);
		write_profile(VMAX[23:0], VMAX[23:0], 24'd1); // huge triangular ramp
		send_sample(28'h8000000);
		send_sample(TMAX[TIME_W-1:0]);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data  <= VAL_W'($urandom_range(0, 32'hFFFFFF));
		@(posedge clk);
		cfg_we <= 1'b0;
		send_sample(28'h4000000);

		for (int ph = 0; ph < 11; ph++) begin
			write_profile(rand_val(), rand_val(), rand_val());
			quiet_in  = (ph % 4 == 1);
			quiet_out = (ph % 4 == 2);
			for (int k = 0; k < 50; k++) begin
				if (ph == 3 && k == 25) drain();
				send_sample(pick_time());
			end
		end
		quiet_in = 1'b0;
		quiet_out = 1'b0;
		drain();
		repeat (20) @(posedge clk);

		$display("%0d time samples over %0d register settings, %0d results checked",
			samples_sent, settings_used, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", sb.mismatches,
				sb.pending.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
